@@ design/utilization_watchdog_backoff_macros.svh @@
// Assertion macros for the utilization watchdog with backoff.
`ifndef UTILIZATION_WATCHDOG_BACKOFF_MACROS_SVH
`define UTILIZATION_WATCHDOG_BACKOFF_MACROS_SVH

`ifndef SYNTHESIS

// Checked on every rising edge outside reset
`define UWB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every rising edge, reset included
`define UWB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`else

`define UWB_ASSERT(lbl, prop, msg)
`define UWB_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

@@ design/uwb_pkg.sv @@
// Types and constants shared by the utilization watchdog with backoff.
package uwb_pkg;

  // Per-unit mode, coded as reported on the result word
  typedef enum logic [1:0] {
    MODE_NORMAL   = 2'd0,
    MODE_WARNING  = 2'd1,
    MODE_CRITICAL = 2'd2
  } mode_e;

  // Action reported for a step
  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_RECOVER = 2'd1,
    ACT_FATAL   = 2'd2
  } act_e;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_FIRST_LOW   = 3'd0,
    CFG_FIRST_CRIT  = 3'd1,
    CFG_SECOND_LOW  = 3'd2,
    CFG_SECOND_CRIT = 3'd3,
    CFG_RUN_LIMIT   = 3'd4,
    CFG_REC_LIMIT   = 3'd5,
    CFG_THERMAL     = 3'd6,
    CFG_BACKOFF     = 3'd7
  } cfg_idx_e;

  localparam int unsigned UtilW  = 10;
  localparam int unsigned TempW  = 12;
  localparam int unsigned RunW   = 16;
  localparam int unsigned RecW   = 8;
  localparam int unsigned ThermW = 11;
  localparam int unsigned StepW  = 32;
  localparam int unsigned BoffW  = 16;
  localparam int unsigned CfgW   = 16;

  // Thermal limit is clamped to 125.0 C
  localparam logic [ThermW-1:0] ThermalClamp = 11'd1250;
  // Shifts at or above this always hit the cap when the base is nonzero
  localparam logic [RecW-1:0]   ShiftMax     = 8'd20;
  localparam logic [RunW-1:0]   RunSat       = 16'hFFFF;

  // Reset values of the configuration registers
  localparam logic [UtilW-1:0]  RstLow      = 10'd200;
  localparam logic [UtilW-1:0]  RstCrit     = 10'd50;
  localparam logic [RunW-1:0]   RstRunLimit = 16'd5;
  localparam logic [RecW-1:0]   RstRecLimit = 8'd3;
  localparam logic [ThermW-1:0] RstThermal  = 11'd850;
  localparam logic [BoffW-1:0]  RstBackoff  = 16'd100;

  // Watchdog state of one unit
  typedef struct packed {
    mode_e           mode;
    logic [RunW-1:0] run;
    logic            latch;
    logic [RecW-1:0] rec;
  } unit_t;

  // Input word fields
  typedef struct packed {
    logic [StepW-1:0]        step;
    logic signed [TempW-1:0] second_temp;
    logic [UtilW-1:0]        second_util;
    logic signed [TempW-1:0] first_temp;
    logic [UtilW-1:0]        first_util;
  } in_word_t;

  // Result word fields
  typedef struct packed {
    logic [RunW-1:0]  second_low_run;
    logic [RunW-1:0]  first_low_run;
    mode_e            second_mode;
    mode_e            first_mode;
    logic [RecW-1:0]  attempt_number;
    logic [BoffW-1:0] backoff_ms;
    logic [StepW-1:0] action_step;
    logic [UtilW-1:0] action_util;
    logic             action_unit;
    act_e             action_kind;
  } out_word_t;

endpackage

@@ design/utilization_watchdog_backoff.sv @@
// Two-unit utilization watchdog: modes, low-run counts, recovery requests with backoff.
// Flow: an accepted word is held in the input register, and its result is registered
// when it advances into the result register; one word per cycle unless the output
// stalls. Each step's unit state is updated as it moves, so the next word sees it.
// Reset: configuration registers take their defaults, both units return to
// normal with counters and latches cleared, both registers empty.
module utilization_watchdog_backoff #(
  parameter int unsigned BACKOFF_CAP_MS = 30000
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Configuration write port
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [uwb_pkg::CfgW-1:0] cfg_wdata_i,
  // Sample stream in
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // first_util[9:0], first_temp[21:10], second_util[31:22], second_temp[43:32],
  // step_index[75:44], zero fill [79:76]
  input  logic [79:0]  s_axis_tdata,
  // Action stream out
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // action_kind[1:0], action_unit[2], action_util[12:3], action_step[44:13],
  // backoff_ms[60:45], attempt_number[68:61], first_mode[70:69],
  // second_mode[72:71], first_low_run[88:73], second_low_run[104:89],
  // zero fill [111:105]
  output logic [111:0] m_axis_tdata
);
  import uwb_pkg::*;

  `include "utilization_watchdog_backoff_macros.svh"

  localparam int unsigned WideW = BoffW + 19;
  localparam logic [WideW-1:0] CapWide = WideW'(BACKOFF_CAP_MS);
  localparam logic [BoffW-1:0] CapMs   = BoffW'(BACKOFF_CAP_MS);

  // Result of one unit's step
  typedef struct packed {
    unit_t nxt;
    act_e  kind;
  } unit_res_t;

  // One watchdog step for a single unit
  function automatic unit_res_t eval_unit(
    unit_t            u,
    logic [UtilW-1:0] util,
    logic             hot,
    logic [UtilW-1:0] low,
    logic [UtilW-1:0] crit,
    logic [RunW-1:0]  run_limit,
    logic [RecW-1:0]  rec_limit
  );
    unit_res_t r;
    logic      warn;
    r.nxt  = u;
    r.kind = ACT_NONE;
    warn   = (util >= crit);
    if (util >= low) begin
      r.nxt.mode  = MODE_NORMAL;
      r.nxt.run   = '0;
      r.nxt.latch = 1'b0;
    end else begin
      if (u.run != RunSat) begin
        r.nxt.run = u.run + 16'd1;
      end
      r.nxt.mode = warn ? MODE_WARNING : MODE_CRITICAL;
      if (!hot && !u.latch && !(warn && (r.nxt.run < run_limit))) begin
        if (u.rec >= rec_limit) begin
          r.nxt.latch = 1'b1;
          if (warn) begin
            r.nxt.run = '0;
          end
          r.kind = ACT_FATAL;
        end else begin
          r.nxt.rec = u.rec + 8'd1;
          r.kind    = ACT_RECOVER;
        end
      end
    end
    return r;
  endfunction

  // Configuration registers
  logic [UtilW-1:0]  first_low_q, first_crit_q, second_low_q, second_crit_q;
  logic [RunW-1:0]   run_limit_q;
  logic [RecW-1:0]   rec_limit_q;
  logic [ThermW-1:0] thermal_q;
  logic [BoffW-1:0]  backoff_base_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_low_q    <= RstLow;
      first_crit_q   <= RstCrit;
      second_low_q   <= RstLow;
      second_crit_q  <= RstCrit;
      run_limit_q    <= RstRunLimit;
      rec_limit_q    <= RstRecLimit;
      thermal_q      <= RstThermal;
      backoff_base_q <= RstBackoff;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_FIRST_LOW:   first_low_q    <= cfg_wdata_i[UtilW-1:0];
        CFG_FIRST_CRIT:  first_crit_q   <= cfg_wdata_i[UtilW-1:0];
        CFG_SECOND_LOW:  second_low_q   <= cfg_wdata_i[UtilW-1:0];
        CFG_SECOND_CRIT: second_crit_q  <= cfg_wdata_i[UtilW-1:0];
        CFG_RUN_LIMIT:   run_limit_q    <= cfg_wdata_i[RunW-1:0];
        CFG_REC_LIMIT:   rec_limit_q    <= cfg_wdata_i[RecW-1:0];
        CFG_THERMAL:     thermal_q      <= cfg_wdata_i[ThermW-1:0];
        CFG_BACKOFF:     backoff_base_q <= cfg_wdata_i[BoffW-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: input register advances into the result register
  logic      in_valid_q, out_valid_q, advance;
  in_word_t  in_q;
  out_word_t out_q, out_d;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_q <= in_word_t'(s_axis_tdata[$bits(in_word_t)-1:0]);
    end
    if (advance) begin
      out_q <= out_d;
    end
  end

  // Thermal check per unit against the clamped limit
  logic [ThermW-1:0] therm_lim;
  logic              hot0, hot1;

  assign therm_lim = (thermal_q > ThermalClamp) ? ThermalClamp : thermal_q;
  assign hot0 = $signed({in_q.first_temp[TempW-1], in_q.first_temp}) >
                $signed({2'b00, therm_lim});
  assign hot1 = $signed({in_q.second_temp[TempW-1], in_q.second_temp}) >
                $signed({2'b00, therm_lim});

  // Unit state and per-unit step
  unit_t     unit0_q, unit1_q;
  unit_res_t res0, res1;

  assign res0 = eval_unit(unit0_q, in_q.first_util, hot0, first_low_q, first_crit_q,
                          run_limit_q, rec_limit_q);
  assign res1 = eval_unit(unit1_q, in_q.second_util, hot1, second_low_q, second_crit_q,
                          run_limit_q, rec_limit_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit0_q <= '{mode: MODE_NORMAL, run: '0, latch: 1'b0, rec: '0};
      unit1_q <= '{mode: MODE_NORMAL, run: '0, latch: 1'b0, rec: '0};
    end else if (advance) begin
      unit0_q <= res0.nxt;
      unit1_q <= res1.nxt;
    end
  end

  // Winner select: the first unit's action takes the result slot, else the second's
  act_e             sel_kind;
  logic             sel_unit;
  logic [UtilW-1:0] sel_util;
  logic [RecW-1:0]  sel_rec;

  always_comb begin
    sel_kind = ACT_NONE;
    sel_unit = 1'b0;
    sel_util = '0;
    sel_rec  = '0;
    if (res0.kind != ACT_NONE) begin
      sel_kind = res0.kind;
      sel_util = in_q.first_util;
      sel_rec  = res0.nxt.rec;
    end else if (res1.kind != ACT_NONE) begin
      sel_kind = res1.kind;
      sel_unit = 1'b1;
      sel_util = in_q.second_util;
      sel_rec  = res1.nxt.rec;
    end
  end

  // Backoff on recovery = base << (n-1), saturated at the cap; zero otherwise
  logic [RecW-1:0]  boff_shift;
  logic [WideW-1:0] boff_wide;
  logic [BoffW-1:0] boff;

  assign boff_shift = sel_rec - 8'd1;
  assign boff_wide  = {19'd0, backoff_base_q} << boff_shift[4:0];

  always_comb begin
    boff = '0;
    if (sel_kind == ACT_RECOVER && backoff_base_q != '0) begin
      if (boff_shift >= ShiftMax || boff_wide > CapWide) begin
        boff = CapMs;
      end else begin
        boff = boff_wide[BoffW-1:0];
      end
    end
  end

  // Result word
  always_comb begin
    out_d.action_kind    = sel_kind;
    out_d.action_unit    = sel_unit;
    out_d.action_util    = sel_util;
    out_d.action_step    = in_q.step;
    out_d.backoff_ms     = boff;
    out_d.attempt_number = sel_rec;
    out_d.first_mode     = res0.nxt.mode;
    out_d.second_mode    = res1.nxt.mode;
    out_d.first_low_run  = res0.nxt.run;
    out_d.second_low_run = res1.nxt.run;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_q};

  // Checks
  logic out_stall;
  assign out_stall = out_valid_q && !m_axis_tready;

  `UWB_ASSERT(a_stall_hold, out_stall |=> $stable({unit0_q, unit1_q}), "state moved in stall")
  `UWB_ASSERT(a_fatal_latch, advance && res0.kind == ACT_FATAL |=> unit0_q.latch, "latch not set")
  `UWB_ASSERT(a_empty_out_ready, !out_valid_q |-> s_axis_tready, "input blocked while empty")
  `UWB_ASSERT_ALWAYS(a_reset_empty, !rst_ni |-> !m_axis_tvalid, "result valid during reset")

endmodule
